/* src/icp_pkg.sv */
package icp_pkg;

  localparam int COUNT_W = 16;
  localparam int MODE_W = 3;
  localparam int CHAN_W = 8;
  localparam int FRACTION_BITS_DEF = 16;
  localparam int SINE_DEPTH_DEF = 1024;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [COUNT_W-1:0] LIMIT_RESET = 16'd25;
  localparam logic [MODE_W-1:0] MODE_RESET = 3'd0;

  localparam logic [MODE_W-1:0] MODE_GREY = 3'd0;
  localparam logic [MODE_W-1:0] MODE_WARM = 3'd1;
  localparam logic [MODE_W-1:0] MODE_TRIG = 3'd2;
  localparam logic [MODE_W-1:0] MODE_SCALED = 3'd3;
  localparam logic [MODE_W-1:0] MODE_SINE = 3'd4;

  localparam logic REG_LIMIT = 1'b0;
  localparam logic REG_MODE = 1'b1;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned INV_TWO_PI_Q24 = 64'd2670177;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic               black;
    logic               sat;
  } icp_item_t;

endpackage

/* src/iteration_count_palette.sv */
// Escape-time palette: maps one pixel's iteration count to 24-bit RGB.
// Input stream: s_tvalid/s_tready/s_tdata, s_tdata[15:0] = iteration count.
// Output stream: m_tvalid/m_tready/m_tdata, red in [7:0], green in [15:8],
// blue in [23:16].
// APB port: register 0 (address 0) iteration limit, register 1 (address 4)
// palette mode. Write only while no pixel is in flight.
// Throughput: one pixel per clock while the receiver keeps m_tready high.
// The restoring divider forms count/limit one quotient bit per stage.
// A count equal to the limit gives black in every mode.
// Reset empties the pipeline and queue, and loads limit 25 and mode 0.
// When the receiver stalls, the back pipeline holds; the queue keeps taking
// pixels until full, after which s_tready drops.
module iteration_count_palette
  import icp_pkg::*;
#(
  parameter int FRACTION_BITS    = FRACTION_BITS_DEF,
  parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DEF,
  parameter int QUEUE_DEPTH      = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,    // iteration_count
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,    // red, green, blue
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [COUNT_W-1:0] iteration_limit;
  logic [MODE_W-1:0]  palette_mode;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_MODE) ? {29'd0, palette_mode} : {16'd0, iteration_limit};

  always_ff @(posedge clk) begin
    if (rst) begin
      iteration_limit <= LIMIT_RESET;
      palette_mode <= MODE_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        REG_LIMIT: iteration_limit <= pwdata[COUNT_W-1:0];
        REG_MODE:  palette_mode <= pwdata[MODE_W-1:0];
        default:   ;
      endcase
    end
  end

  logic                   f_valid;
  logic                   f_ready;
  icp_item_t              f_item;
  logic                   q_valid;
  icp_item_t              q_item;
  logic                   adv;
  logic                   d_valid;
  logic [FRACTION_BITS:0] d_t;
  icp_item_t              d_item;

  icp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .limit     (iteration_limit),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .out_item  (f_item)
  );

  icp_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_item   (f_item),
    .out_valid (q_valid),
    .out_ready (adv),
    .out_item  (q_item)
  );

  icp_div #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .limit     (iteration_limit),
    .in_valid  (q_valid),
    .in_item   (q_item),
    .out_valid (d_valid),
    .out_t     (d_t),
    .out_item  (d_item)
  );

  icp_color #(
    .FRACTION_BITS    (FRACTION_BITS),
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_color (
    .clk      (clk),
    .rst      (rst),
    .mode     (palette_mode),
    .in_valid (d_valid),
    .in_t     (d_t),
    .in_item  (d_item),
    .adv      (adv),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

/* src/icp_front.sv */
module icp_front
  import icp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic [COUNT_W-1:0] limit,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [15:0]        s_tdata,   // iteration_count
  output logic               out_valid,
  input  logic               out_ready,
  output icp_item_t          out_item
);

  logic      fvalid;
  icp_item_t fitem;
  icp_item_t fitem_next;

  assign s_tready = !fvalid || out_ready;
  assign out_valid = fvalid;
  assign out_item = fitem;

  always_comb begin
    fitem_next.count = s_tdata;
    fitem_next.black = (s_tdata == limit);
    fitem_next.sat = (limit == '0) || (s_tdata >= limit);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fvalid <= 1'b0;
    end else if (s_tready) begin
      fvalid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      fitem <= fitem_next;
    end
  end

endmodule

/* src/icp_fifo.sv */
module icp_fifo
  import icp_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  icp_item_t in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output icp_item_t out_item
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  icp_item_t          mem [0:DEPTH-1];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               push;
  logic               pop;

  assign in_ready = (count != CNT_W'(DEPTH));
  assign out_valid = (count != '0);
  assign out_item = mem[rd_ptr];
  assign push = in_valid && in_ready;
  assign pop = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_item;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (rst)
    count == '0 |-> wr_ptr == rd_ptr)
    else $error("empty queue with pointers apart");

  a_push_only: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + CNT_W'(1))
    else $error("queue count lost a transfer");

endmodule

/* src/icp_div.sv */
module icp_div
  import icp_pkg::*;
#(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     adv,
  input  logic [COUNT_W-1:0]       limit,
  input  logic                     in_valid,
  input  icp_item_t                in_item,
  output logic                     out_valid,
  output logic [FRACTION_BITS:0]   out_t,
  output icp_item_t                out_item
);

  localparam int FB = FRACTION_BITS;

  logic                 vld      [0:FB];
  logic [COUNT_W-1:0]   rem      [0:FB];
  logic [FB-1:0]        quo      [0:FB];
  icp_item_t            itm      [0:FB];
  logic [COUNT_W-1:0]   rem_next [0:FB-1];
  logic [FB-1:0]        quo_next [0:FB-1];

  for (genvar s = 0; s < FB; s++) begin : g_step
    logic [COUNT_W:0] rem2;
    logic [COUNT_W:0] diff;
    logic             ge;
    assign rem2 = {rem[s], 1'b0};
    assign ge = rem2 >= {1'b0, limit};
    assign diff = rem2 - {1'b0, limit};
    assign rem_next[s] = ge ? diff[COUNT_W-1:0] : rem2[COUNT_W-1:0];
    assign quo_next[s] = FB'({quo[s], ge});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s <= FB; s++) begin
        vld[s] <= 1'b0;
      end
    end else if (adv) begin
      vld[0] <= in_valid;
      for (int s = 0; s < FB; s++) begin
        vld[s+1] <= vld[s];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem[0] <= in_item.count;
      quo[0] <= '0;
      itm[0] <= in_item;
      for (int s = 0; s < FB; s++) begin
        rem[s+1] <= rem_next[s];
        quo[s+1] <= quo_next[s];
        itm[s+1] <= itm[s];
      end
    end
  end

  assign out_valid = vld[FB];
  assign out_item = itm[FB];
  assign out_t = itm[FB].sat ? {1'b1, {FB{1'b0}}} : {1'b0, quo[FB]};

endmodule

/* src/icp_color.sv */
module icp_color
  import icp_pkg::*;
#(
  parameter int FRACTION_BITS    = FRACTION_BITS_DEF,
  parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [MODE_W-1:0]       mode,
  input  logic                    in_valid,
  input  logic [FRACTION_BITS:0]  in_t,
  input  icp_item_t               in_item,
  output logic                    adv,
  output logic                    m_tvalid,
  input  logic                    m_tready,
  output logic [23:0]             m_tdata    // red, green, blue
);

  localparam int FB = FRACTION_BITS;
  localparam int LD = $clog2(SINE_TABLE_DEPTH);
  localparam int QTR = SINE_TABLE_DEPTH / 4;
  localparam int KW = FB + 3;
  localparam int PW = FB + 26;
  localparam int LW = FB + 9;
  localparam longint unsigned Q30 = 64'd1 << 30;
  localparam logic [24:0] SC5 = 25'(5 * INV_TWO_PI_Q24);
  localparam logic [24:0] SC7 = 25'(7 * INV_TWO_PI_Q24);
  localparam logic [24:0] SC11 = 25'(11 * INV_TWO_PI_Q24);

  function automatic logic [14:0] sine_mag(input int rr);
    longint unsigned y;
    longint unsigned y2;
    longint unsigned a;
    longint unsigned sv;
    longint unsigned mag;
    y = (64'(4 * rr) * HALF_PI_Q30) / SINE_TABLE_DEPTH;
    y2 = (y * y) >> 30;
    a = Q30 - y2 / 72;
    a = Q30 - ((y2 * a) >> 30) / 42;
    a = Q30 - ((y2 * a) >> 30) / 20;
    a = Q30 - ((y2 * a) >> 30) / 6;
    sv = (y * a) >> 30;
    mag = (sv + 64'd16384) >> 15;
    if (mag > 64'd32767) begin
      mag = 64'd32767;
    end
    return mag[14:0];
  endfunction

  function automatic logic [7:0] div32767(input logic [23:0] y);
    logic [8:0]  q0;
    logic [15:0] rem;
    logic [8:0]  q;
    q0 = y[23:15];
    rem = {1'b0, y[14:0]} + {7'd0, q0};
    q = (rem >= 16'd32767) ? q0 + 9'd1 : q0;
    return q[7:0];
  endfunction

  logic [14:0] sine_tbl [0:QTR];

  for (genvar i = 0; i <= QTR; i++) begin : g_tbl
    localparam logic [14:0] V = sine_mag(i);
    assign sine_tbl[i] = V;
  end

  // stage 1: table index and direct colors
  logic [KW-1:0]  t2;
  logic [KW-1:0]  t3;
  logic [PW-1:0]  p5;
  logic [PW-1:0]  p7;
  logic [PW-1:0]  p11;
  logic [LW-1:0]  p255;
  logic [LW-1:0]  p128;
  logic [LW-1:0]  p64;
  logic [LW-1:0]  p51;
  logic [LW-1:0]  p204;
  logic [LW-1:0]  p153;
  logic [LD-1:0]  idx_next [0:2];
  logic [23:0]    direct_next;
  logic [15:0]    n;

  assign t2 = KW'(in_t) << 1;
  assign t3 = KW'(in_t) * KW'(3);
  assign p5 = PW'(in_t) * PW'(SC5);
  assign p7 = PW'(in_t) * PW'(SC7);
  assign p11 = PW'(in_t) * PW'(SC11);
  assign p255 = LW'(in_t) * LW'(255);
  assign p128 = LW'(in_t) << 7;
  assign p64 = LW'(in_t) << 6;
  assign p51 = LW'(in_t) * LW'(51);
  assign p204 = LW'(in_t) * LW'(204);
  assign p153 = LW'(in_t) * LW'(153);
  assign n = in_item.count;

  always_comb begin
    if (mode == MODE_TRIG) begin
      idx_next[0] = LD'({t2, {LD{1'b0}}} >> FB);
      idx_next[1] = LD'({t2, {LD{1'b0}}} >> FB) + LD'(QTR);
      idx_next[2] = LD'({t3, {LD{1'b0}}} >> FB);
    end else begin
      idx_next[0] = LD'(p5 >> (FB + 24 - LD));
      idx_next[1] = LD'(p7 >> (FB + 24 - LD));
      idx_next[2] = LD'(p11 >> (FB + 24 - LD));
    end
  end

  always_comb begin
    unique case (mode)
      MODE_GREY: begin
        direct_next = {3{8'(p255 >> FB)}};
      end
      MODE_WARM: begin
        direct_next = {8'(p64 >> FB), 8'(p128 >> FB), 8'(p255 >> FB)};
      end
      MODE_SCALED: begin
        direct_next = {8'(p153 >> FB), 8'(p204 >> FB), 8'(p51 >> FB)};
      end
      default: begin
        direct_next = {8'((n[7:0] << 2) + n[7:0]), {n[6:0], 1'b0},
                       8'((n[7:0] << 3) + n[7:0])};
      end
    endcase
  end

  logic           c1_vld;
  logic [LD-1:0]  c1_idx [0:2];
  logic [23:0]    c1_direct;
  logic           c1_black;

  // stage 2: quarter-wave lookup, offset to unsigned
  logic [15:0]    u_next [0:2];

  for (genvar ch = 0; ch < 3; ch++) begin : g_look
    logic [1:0]    quad;
    logic [LD-3:0] r;
    logic [LD-2:0] rr;
    logic [14:0]   mag;
    assign quad = c1_idx[ch][LD-1:LD-2];
    assign r = c1_idx[ch][LD-3:0];
    assign rr = quad[0] ? (LD-1)'(QTR) - {1'b0, r} : {1'b0, r};
    assign mag = sine_tbl[rr];
    assign u_next[ch] = quad[1] ? 16'd32767 - {1'b0, mag} : 16'd32767 + {1'b0, mag};
  end

  logic           c2_vld;
  logic [15:0]    c2_u [0:2];
  logic [23:0]    c2_direct;
  logic           c2_black;

  // output stage: channel scaling
  logic [23:0]    color_next;

  for (genvar ch = 0; ch < 3; ch++) begin : g_chan
    logic [23:0] y255;
    logic [23:0] y127;
    logic [7:0]  chan;
    assign y255 = 24'(c2_u[ch]) * 24'(255);
    assign y127 = 24'(c2_u[ch]) * 24'(127);
    always_comb begin
      if (c2_black) begin
        chan = '0;
      end else if (mode == MODE_TRIG) begin
        chan = div32767(y255 >> 1);
      end else if (mode == MODE_SINE) begin
        chan = div32767(y127) + 8'd1;
      end else begin
        chan = c2_direct[ch*8 +: 8];
      end
    end
    assign color_next[ch*8 +: 8] = chan;
  end

  assign adv = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      c1_vld <= 1'b0;
      c2_vld <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (adv) begin
      c1_vld <= in_valid;
      c2_vld <= c1_vld;
      m_tvalid <= c2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int ch = 0; ch < 3; ch++) begin
        c1_idx[ch] <= idx_next[ch];
        c2_u[ch] <= u_next[ch];
      end
      c1_direct <= direct_next;
      c1_black <= in_item.black;
      c2_direct <= c1_direct;
      c2_black <= c1_black;
      m_tdata <= color_next;
    end
  end

endmodule

/* bench/tb_top.sv */
module tb_top
  import icp_pkg::*;
();

  localparam int FB = 16;
  localparam int DEPTH = 1024;
  localparam int LATENCY = FB + 5;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;    // iteration_count
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;    // red, green, blue
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  iteration_count_palette u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  int signed   sine_lut [DEPTH];
  logic [15:0] cur_limit;
  logic [2:0]  cur_mode;
  rgb_t        pending_colors [$];
  int          errors;
  int          rx_stall_max;
  int          rx_hold;

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  function automatic int signed sine_at(int unsigned i);
    longint unsigned four, q, r, y, y2, a, s, mag;
    four = 4 * longint'(i);
    q = four / DEPTH;
    r = four - q * DEPTH;
    if (q[0]) r = DEPTH - r;
    y = (r * HALF_PI_Q30) / DEPTH;
    y2 = (y * y) >> 30;
    a = (64'd1 << 30) - y2 / 72;
    a = (64'd1 << 30) - ((y2 * a) >> 30) / 42;
    a = (64'd1 << 30) - ((y2 * a) >> 30) / 20;
    a = (64'd1 << 30) - ((y2 * a) >> 30) / 6;
    s = (y * a) >> 30;
    mag = (s + (64'd1 << 14)) >> 15;
    if (mag > 32767) mag = 32767;
    return (q >= 2) ? -int'(mag) : int'(mag);
  endfunction

  function automatic logic [7:0] trig_level(longint unsigned k, longint unsigned t,
                                            longint unsigned offs);
    longint unsigned idx;
    idx = (((k * t * DEPTH) >> FB) + offs) % DEPTH;
    return 8'((255 * longint'(sine_lut[idx] + 32767)) / 65534);
  endfunction

  function automatic logic [7:0] wave_level(longint unsigned k, longint unsigned t);
    longint unsigned idx;
    idx = ((k * t * DEPTH * INV_TWO_PI_Q24) >> (FB + 24)) % DEPTH;
    return 8'(1 + (127 * longint'(sine_lut[idx] + 32767)) / 32767);
  endfunction

  function automatic rgb_t color_of(logic [15:0] n);
    rgb_t c;
    longint unsigned t;
    c = '{8'd0, 8'd0, 8'd0};
    if (n == cur_limit) return c;
    if (cur_limit == 0 || n >= cur_limit) t = 64'd1 << FB;
    else t = (longint'(n) << FB) / cur_limit;
    case (cur_mode)
      MODE_GREY: begin
        c.red = 8'((255 * t) >> FB);
        c.green = c.red;
        c.blue = c.red;
      end
      MODE_WARM: begin
        c.red = 8'((255 * t) >> FB);
        c.green = 8'((128 * t) >> FB);
        c.blue = 8'((64 * t) >> FB);
      end
      MODE_TRIG: begin
        c.red = trig_level(2, t, 0);
        c.green = trig_level(2, t, DEPTH / 4);
        c.blue = trig_level(3, t, 0);
      end
      MODE_SCALED: begin
        c.red = 8'((51 * t) >> FB);
        c.green = 8'((204 * t) >> FB);
        c.blue = 8'((153 * t) >> FB);
      end
      MODE_SINE: begin
        c.red = wave_level(5, t);
        c.green = wave_level(7, t);
        c.blue = wave_level(11, t);
      end
      default: begin
        c.red = 8'(9 * longint'(n));
        c.green = 8'(2 * longint'(n));
        c.blue = 8'(5 * longint'(n));
      end
    endcase
    return c;
  endfunction

  function automatic int gap_len();
    if ($urandom_range(0, 3) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    return $urandom_range(0, 3);
  endfunction

  task automatic apb_write(logic [0:0] regsel, logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {regsel, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (regsel == REG_LIMIT) cur_limit = value[15:0];
    else cur_mode = value[2:0];
  endtask

  task automatic send_count(logic [15:0] n, bit with_gaps);
    int g;
    g = with_gaps ? gap_len() : 0;
    if (g != 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= n;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_colors.push_back(color_of(n));
    @(negedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_colors.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic test_directed_extremes();
    logic [15:0] vals [8];
    vals = '{16'd0, 16'd1, 16'd24, 16'd25, 16'd26, 16'hFFFF, 16'h8000, 16'h7FFF};
    for (int m = 0; m < 8; m++) begin
      apb_write(REG_MODE, 32'(m));
      foreach (vals[i]) send_count(vals[i], 1'b0);
      drain();
    end
  endtask

  task automatic test_limit_corners();
    apb_write(REG_LIMIT, 32'd0);
    apb_write(REG_MODE, 32'(MODE_GREY));
    send_count(16'd0, 1'b0);
    send_count(16'd5, 1'b0);
    send_count(16'hFFFF, 1'b0);
    drain();
    apb_write(REG_LIMIT, 32'hFFFF_FFFF);
    apb_write(REG_MODE, 32'hFFFF_FFFC);
    send_count(16'hFFFF, 1'b0);
    send_count(16'hFFFE, 1'b0);
    send_count(16'd1, 1'b0);
    drain();
  endtask

  task automatic test_random_phases();
    logic [15:0] n;
    for (int p = 0; p < 24; p++) begin
      case ($urandom_range(0, 4))
        0: apb_write(REG_LIMIT, 32'd1);
        1: apb_write(REG_LIMIT, 32'hFFFF);
        default: apb_write(REG_LIMIT, 32'($urandom_range(1, 65535)));
      endcase
      apb_write(REG_MODE, $urandom);
      rx_stall_max = (p % 3 == 0) ? 0 : 1;
      for (int i = 0; i < 80; i++) begin
        case ($urandom_range(0, 5))
          0: n = cur_limit;
          1: n = 16'($urandom);
          default: n = 16'($urandom_range(0, 2 * cur_limit));
        endcase
        send_count(n, p % 4 != 0);
      end
      drain();
    end
  endtask

  always @(negedge clk) begin
    if (rst || rx_stall_max == 0) begin
      rx_hold = 0;
      m_tready <= 1'b1;
    end else if (rx_hold != 0) begin
      rx_hold = rx_hold - 1;
      m_tready <= 1'b0;
    end else begin
      rx_hold = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
      if (rx_hold != 0) begin
        rx_hold = rx_hold - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    rgb_t exp_c;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_colors.size() == 0) begin
        $display("%0t: unexpected transfer %h", $time, m_tdata);
        errors++;
      end else begin
        exp_c = pending_colors.pop_front();
        if (m_tdata[7:0] !== exp_c.red) begin
          $display("%0t: red expected %h actual %h", $time, exp_c.red, m_tdata[7:0]);
          errors++;
        end
        if (m_tdata[15:8] !== exp_c.green) begin
          $display("%0t: green expected %h actual %h", $time, exp_c.green, m_tdata[15:8]);
          errors++;
        end
        if (m_tdata[23:16] !== exp_c.blue) begin
          $display("%0t: blue expected %h actual %h", $time, exp_c.blue, m_tdata[23:16]);
          errors++;
        end
      end
    end
  end

  initial begin
    #4000000;
    $display("tb_top failed");
    $finish;
  end

  initial begin
    errors = 0;
    rx_stall_max = 0;
    rx_hold = 0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    m_tready = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    cur_limit = LIMIT_RESET;
    cur_mode = MODE_RESET;
    for (int i = 0; i < DEPTH; i++) sine_lut[i] = sine_at(i);
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    send_count(16'd25, 1'b0);
    send_count(16'd12, 1'b0);
    drain();
    test_directed_extremes();
    test_limit_corners();
    test_random_phases();
    if (pending_colors.size() == 0 && errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
